// File: rtl/wsd_pkg.sv
// shared types and constants for the websocket frame deframer
`default_nettype none

package wsd_pkg;

    // parse phases
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_HALT    = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // fault codes
    localparam logic FAULT_RESERVED = 1'b0;
    localparam logic FAULT_LENGTH   = 1'b1;

    // header bit fields and length markers
    localparam logic [7:0] HDR_FIN_BIT   = 8'h80;
    localparam logic [7:0] HDR_RSV_BITS  = 8'h70;
    localparam logic [7:0] HDR_OPC_BITS  = 8'h0F;
    localparam logic [7:0] HDR_LEN7_BITS = 8'h7F;
    localparam logic [6:0] LEN_MARK_16   = 7'd126;
    localparam logic [6:0] LEN_MARK_64   = 7'd127;

    // byte counts of the variable header fields
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    localparam logic [31:0] MAX_LEN_RESET = 32'h4000_0000;

    // packed width of the result tdata
    localparam int TDATA_W = 48;

    typedef struct packed {
        logic [1:0]  kind;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [31:0] length;
        logic [7:0]  data;
        logic        last;
        logic        fault;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/wsd_front.sv
// header parser and payload unmasker, one byte per cycle while in_fire is asserted
`default_nettype none

module wsd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_fire,
    input  wire logic [7:0]    in_byte,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata,
    output logic               push,
    output wsd_pkg::res_t      push_res
);

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opc_reg, opc_next;
    logic        masked_reg, masked_next;
    logic [31:0] max_reg;

    logic [63:0] ext_len;
    logic [63:0] hdr_len;
    logic        len_over;
    logic        len_zero;
    logic [7:0]  key_byte;
    logic [6:0]  len7;
    logic        do_len_done;
    logic        do_finish;

    assign ext_len = {len_reg[55:0], in_byte};
    assign len7    = in_byte[6:0] & wsd_pkg::HDR_LEN7_BITS[6:0];

    // length that completes the header in this cycle
    always_comb begin
        case (phase_reg)
            wsd_pkg::PH_HDR1:   hdr_len = {57'd0, len7};
            wsd_pkg::PH_EXTLEN: hdr_len = ext_len;
            default:            hdr_len = len_reg;
        endcase
    end

    assign len_over = (hdr_len[63:32] != 32'd0) || (hdr_len[31:0] > max_reg);
    assign len_zero = (hdr_len == 64'd0);

    // first key byte sits in the top bits
    always_comb begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        fin_next    = fin_reg;
        opc_next    = opc_reg;
        masked_next = masked_reg;
        do_len_done = 1'b0;
        do_finish   = 1'b0;
        push        = 1'b0;
        push_res    = '0;

        if (in_fire) begin
            case (phase_reg)
                wsd_pkg::PH_HDR0: begin
                    fin_next    = (in_byte & wsd_pkg::HDR_FIN_BIT) != 8'd0;
                    opc_next    = in_byte[3:0] & wsd_pkg::HDR_OPC_BITS[3:0];
                    masked_next = 1'b0;
                    if ((in_byte & wsd_pkg::HDR_RSV_BITS) != 8'd0) begin
                        phase_next     = wsd_pkg::PH_HALT;
                        push           = 1'b1;
                        push_res.kind  = wsd_pkg::KIND_ERROR;
                        push_res.last  = 1'b1;
                        push_res.fault = wsd_pkg::FAULT_RESERVED;
                    end else begin
                        phase_next = wsd_pkg::PH_HDR1;
                    end
                end
                wsd_pkg::PH_HDR1: begin
                    masked_next = (in_byte & wsd_pkg::HDR_FIN_BIT) != 8'd0;
                    if (len7 == wsd_pkg::LEN_MARK_16) begin
                        len_next   = 64'd0;
                        cnt_next   = wsd_pkg::EXT16_BYTES;
                        phase_next = wsd_pkg::PH_EXTLEN;
                    end else if (len7 == wsd_pkg::LEN_MARK_64) begin
                        len_next   = 64'd0;
                        cnt_next   = wsd_pkg::EXT64_BYTES;
                        phase_next = wsd_pkg::PH_EXTLEN;
                    end else begin
                        len_next    = hdr_len;
                        do_len_done = 1'b1;
                    end
                end
                wsd_pkg::PH_EXTLEN: begin
                    len_next = ext_len;
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1) begin
                        do_len_done = 1'b1;
                    end
                end
                wsd_pkg::PH_MASK: begin
                    key_next = {key_reg[23:0], in_byte};
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1) begin
                        do_finish = 1'b1;
                    end
                end
                wsd_pkg::PH_PAYLOAD: begin
                    idx_next      = idx_reg + 2'd1;
                    len_next      = len_reg - 64'd1;
                    push          = 1'b1;
                    push_res.kind = wsd_pkg::KIND_PAYLOAD;
                    push_res.data = masked_reg ? (in_byte ^ key_byte) : in_byte;
                    if (len_reg == 64'd1) begin
                        push_res.last = 1'b1;
                        phase_next    = wsd_pkg::PH_HDR0;
                    end
                end
                default: begin
                    phase_next = wsd_pkg::PH_HALT;
                end
            endcase

            // length complete: fetch the key or close the header
            if (do_len_done) begin
                key_next = 32'd0;
                if (masked_next) begin
                    cnt_next   = wsd_pkg::MASK_BYTES;
                    phase_next = wsd_pkg::PH_MASK;
                end else begin
                    do_finish = 1'b1;
                end
            end

            if (do_finish) begin
                push = 1'b1;
                if (len_over) begin
                    phase_next     = wsd_pkg::PH_HALT;
                    push_res.kind  = wsd_pkg::KIND_ERROR;
                    push_res.last  = 1'b1;
                    push_res.fault = wsd_pkg::FAULT_LENGTH;
                end else if (len_zero) begin
                    phase_next    = wsd_pkg::PH_HDR0;
                    push_res.kind = wsd_pkg::KIND_HEADER;
                    push_res.last = 1'b1;
                end else begin
                    idx_next        = 2'd0;
                    phase_next      = wsd_pkg::PH_PAYLOAD;
                    push_res.kind   = wsd_pkg::KIND_HEADER;
                    push_res.length = hdr_len[31:0];
                end
            end

            push_res.fin    = fin_next;
            push_res.opcode = opc_next;
            push_res.masked = masked_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= wsd_pkg::PH_HDR0;
            cnt_reg    <= 4'd0;
            len_reg    <= 64'd0;
            key_reg    <= 32'd0;
            idx_reg    <= 2'd0;
            fin_reg    <= 1'b0;
            opc_reg    <= 4'd0;
            masked_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
            fin_reg    <= fin_next;
            opc_reg    <= opc_next;
            masked_reg <= masked_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= wsd_pkg::MAX_LEN_RESET;
        end else if (cfg_we) begin
            max_reg <= cfg_wdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/wsd_queue.sv
// short result queue between parser and output stage
`default_nettype none

module wsd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire wsd_pkg::res_t   push_res,
    input  wire logic            pop,
    output logic                 head_valid,
    output wsd_pkg::res_t        head_res,
    output logic                 full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    wsd_pkg::res_t slot_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign head_valid = (cnt_reg != '0);
    assign head_res   = slot_reg[rd_ptr_reg];
    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign count      = cnt_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_res;
        end
    end

endmodule

`default_nettype wire

// File: rtl/wsd_back.sv
// output register stage that packs results onto the master stream
`default_nettype none

module wsd_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         head_valid,
    input  wire wsd_pkg::res_t                head_res,
    output logic                              pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [wsd_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tlast,
    output logic [1:0]                        m_tuser
);

    logic          valid_reg, valid_next;
    wsd_pkg::res_t res_reg;

    assign pop = head_valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= head_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {1'b0, res_reg.fault, res_reg.data, res_reg.length,
                       res_reg.masked, res_reg.opcode, res_reg.fin};

endmodule

`default_nettype wire

// File: rtl/websocket_frame_deframer_core.sv
// websocket frame deframer top level: parser, result queue, output register
// path: a byte that yields a result is written to the result queue, then to the output register behind m_tvalid
// throughput: one byte per cycle; s_tready drops only while the result queue is full
// header, extension and key bytes are parsed in the registered front state update
// reset: aresetn synchronous active low; clears parser, queue and output valid,
// and restores the payload length limit to 2^30
`default_nettype none

module websocket_frame_deframer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] stream_byte
    // result stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [0] final_fragment, [4:1] frame_opcode, [5] was_masked,
    // [37:6] payload_length, [45:38] payload_data, [46] fault_code, [47] zero
    output logic [wsd_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tlast,   // frame_last
    output logic [1:0]                        m_tuser,   // [1:0] result_kind
    // length limit register
    input  wire logic                         cfg_we,
    input  wire logic [31:0]                  cfg_wdata
);

    logic                               in_fire;
    logic                               push;
    wsd_pkg::res_t                      push_res;
    logic                               pop;
    logic                               head_valid;
    wsd_pkg::res_t                      head_res;
    logic                               q_full;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count;

    // a word is taken whenever the queue has room, also while halted
    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    // front: parse and unmask, at most one result per byte
    wsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .push_res  (push_res)
    );

    // queue decouples parser from output backpressure
    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_res   (push_res),
        .pop        (pop),
        .head_valid (head_valid),
        .head_res   (head_res),
        .full       (q_full),
        .count      (q_count)
    );

    // back: registered master side
    wsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_res   (head_res),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // an error is the last word ever sent until reset
    a_error_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && (m_tuser == wsd_pkg::KIND_ERROR)) |=> !m_tvalid)
        else $error("word sent after error");

    // error words close the frame and carry no length
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == wsd_pkg::KIND_ERROR)) |->
        (m_tlast && (m_tdata[37:6] == 32'd0)))
        else $error("malformed error word");

    // queue occupancy stays within depth and push only with room
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)) && !(push && q_full))
        else $error("result queue overflow");

endmodule

`default_nettype wire
